// ----- rtl/hcct_pkg.sv -----
// ----------------------------------------------------------------------------
// HCI command credit tracker package
// Shared sizes, field types, register indices and reset values, request codes and outcome codes.
// ----------------------------------------------------------------------------
package hcct_pkg;

  localparam int CACHE_DEPTH   = 32;
  localparam int PENDING_DEPTH = 16;
  localparam int EXPIRED_DEPTH = 16;
  localparam int MAX_RESULTS   = 32;

  localparam int CAW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CCW = $clog2(CACHE_DEPTH + 1);
  localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PLW = $clog2(PENDING_DEPTH + 1);
  localparam int EAW = (EXPIRED_DEPTH > 1) ? $clog2(EXPIRED_DEPTH) : 1;
  localparam int ELW = $clog2(EXPIRED_DEPTH + 1);
  localparam int SW  = (PLW > ELW) ? PLW : ELW;
  localparam int NW  = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] TIMEOUT_RESET    = 16'(10 * 1000);
  localparam logic [15:0] ABSORB_RESET     = 16'(2 * 10 * 1000);
  localparam logic [15:0] DISCONNECT_RESET = 16'd1030;

  localparam logic [1:0] CFG_TIMEOUT    = 2'd0;
  localparam logic [1:0] CFG_ABSORB     = 2'd1;
  localparam logic [1:0] CFG_DISCONNECT = 2'd2;

  localparam logic [2:0] REQ_SEND     = 3'd0;
  localparam logic [2:0] REQ_CREDITS  = 3'd1;
  localparam logic [2:0] REQ_STATUS   = 3'd2;
  localparam logic [2:0] REQ_COMPLETE = 3'd3;
  localparam logic [2:0] REQ_TICK     = 3'd4;

  localparam logic [3:0] OC_TRANSMIT    = 4'd0;
  localparam logic [3:0] OC_CACHED      = 4'd1;
  localparam logic [3:0] OC_CACHE_FULL  = 4'd2;
  localparam logic [3:0] OC_PEND_FULL   = 4'd3;
  localparam logic [3:0] OC_OK          = 4'd4;
  localparam logic [3:0] OC_FAILED      = 4'd5;
  localparam logic [3:0] OC_ABSORBED    = 4'd6;
  localparam logic [3:0] OC_NO_PENDING  = 4'd7;
  localparam logic [3:0] OC_TIMEOUT     = 4'd8;
  localparam logic [3:0] OC_TIMEOUT_ZERO = 4'd9;
  localparam logic [3:0] OC_DISCONNECT  = 4'd10;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] op;
  } cache_entry_t;

  typedef struct packed {
    logic [31:0] dl;
    logic [7:0]  tag;
    logic [15:0] op;
  } pend_entry_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] op;
  } exp_entry_t;

endpackage

// ----- rtl/hci_command_credit_tracker.sv -----
// ----------------------------------------------------------------------------
// HCI command credit tracker
// Send, status, complete and tick transactions under a credit count.
// ----------------------------------------------------------------------------
// Send: the result is registered in S_SEND once the output register is free;
// the next transaction is accepted back in idle. Set credits: each drained
// cache entry passes through S_DCHK (read) and S_DEMIT (emit). Status or
// complete: aged expired entries are pruned, then the pending and expired
// tables are scanned; tick scans pending entries. One transaction is worked on
// at a time. Reset clears all control state at once; there is no clearing pass.
module hci_command_credit_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_opcode,
  input  logic [7:0]  in_cmd_tag,
  input  logic [7:0]  in_answer_status,
  input  logic [7:0]  in_credit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_outcome,
  output logic [15:0] out_opcode,
  output logic [7:0]  out_tag,
  output logic [7:0]  out_status,
  output logic        out_last
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEND   = 4'd1;
  localparam logic [3:0] S_DCHK   = 4'd2;
  localparam logic [3:0] S_DEMIT  = 4'd3;
  localparam logic [3:0] S_PRUNE  = 4'd4;
  localparam logic [3:0] S_PSCAN  = 4'd5;
  localparam logic [3:0] S_ESCAN  = 4'd6;
  localparam logic [3:0] S_AEMIT  = 4'd7;
  localparam logic [3:0] S_TICK   = 4'd8;
  localparam logic [3:0] S_TFLUSH = 4'd9;

  logic [15:0] timeout_r, absorb_r, disc_r;
  logic [3:0]  state_r, state_nxt;
  logic [2:0]  req_r, req_nxt;
  logic [15:0] op_r, op_nxt;
  logic [7:0]  tag_r, tag_nxt, st_r, st_nxt;
  logic [7:0]  credits_r, credits_nxt;
  logic [31:0] now_r, now_nxt;
  logic [hcct_pkg::CCW-1:0] count_r, count_nxt;
  logic [hcct_pkg::CAW-1:0] head_r, head_nxt;
  logic [hcct_pkg::PLW-1:0] plen_r, plen_nxt;
  logic [hcct_pkg::ELW-1:0] elen_r, elen_nxt;
  logic [hcct_pkg::SW-1:0]  idx_r, idx_nxt;
  logic [hcct_pkg::NW-1:0]  n_r, n_nxt;

  hcct_pkg::pend_entry_t pend_r [hcct_pkg::PENDING_DEPTH];
  hcct_pkg::exp_entry_t  exp_r  [hcct_pkg::EXPIRED_DEPTH];

  logic        hold_v_r, hold_v_nxt;
  logic [3:0]  hold_oc_r, hold_oc_nxt;
  logic [15:0] hold_op_r, hold_op_nxt;
  logic [7:0]  hold_tag_r, hold_tag_nxt;

  logic        ov_r, ov_nxt, ol_r, ol_nxt;
  logic [3:0]  oc_r, oc_nxt;
  logic [15:0] oop_r, oop_nxt;
  logic [7:0]  otag_r, otag_nxt, ost_r, ost_nxt;

  logic        emit;
  logic [3:0]  e_oc;
  logic [15:0] e_op;
  logic [7:0]  e_tag, e_st;
  logic        e_last;

  logic        pend_add, pend_rm, exp_add, exp_rm;
  hcct_pkg::pend_entry_t pend_new;
  logic [hcct_pkg::SW-1:0] rm_idx;

  logic        ram_we, ram_re;
  logic [hcct_pkg::CAW-1:0] ram_waddr;
  hcct_pkg::cache_entry_t ram_wdata, ram_rdata;
  logic [hcct_pkg::CCW:0] wsum;

  logic        out_free, pend_full;
  hcct_pkg::pend_entry_t pcur;
  hcct_pkg::exp_entry_t  ecur;
  logic [31:0] pdiff, ediff;
  logic [7:0]  cred_after;

  hcct_cache_ram u_cache (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign out_free  = !ov_r || !out_stall;
  assign pend_full = (plen_r == hcct_pkg::PLW'(hcct_pkg::PENDING_DEPTH));
  assign pcur      = pend_r[idx_r[hcct_pkg::PAW-1:0]];
  assign ecur      = exp_r[idx_r[hcct_pkg::EAW-1:0]];
  assign pdiff     = now_r - pcur.dl;
  assign ediff     = now_r - ecur.stamp;
  assign cred_after = pend_full ? credits_r : credits_r - 8'd1;
  assign wsum      = {1'b0, head_r} + (hcct_pkg::CCW + 1)'(count_r);
  assign ram_waddr = (wsum >= (hcct_pkg::CCW + 1)'(hcct_pkg::CACHE_DEPTH))
                     ? hcct_pkg::CAW'(wsum - (hcct_pkg::CCW + 1)'(hcct_pkg::CACHE_DEPTH))
                     : hcct_pkg::CAW'(wsum);
  assign ram_wdata = '{tag: tag_r, op: op_r};
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;  req_nxt = req_r;  op_nxt = op_r;
    tag_nxt = tag_r;  st_nxt = st_r;  credits_nxt = credits_r;
    now_nxt = now_r;  count_nxt = count_r;  head_nxt = head_r;
    plen_nxt = plen_r;  elen_nxt = elen_r;  idx_nxt = idx_r;  n_nxt = n_r;
    hold_v_nxt = hold_v_r;  hold_oc_nxt = hold_oc_r;
    hold_op_nxt = hold_op_r;  hold_tag_nxt = hold_tag_r;
    emit = 1'b0;  e_oc = hcct_pkg::OC_TRANSMIT;  e_op = op_r;
    e_tag = tag_r;  e_st = 8'd0;  e_last = 1'b1;
    pend_add = 1'b0;  pend_rm = 1'b0;  exp_add = 1'b0;  exp_rm = 1'b0;
    pend_new = '{dl: now_r + 32'(timeout_r), tag: tag_r, op: op_r};
    rm_idx = idx_r;  ram_we = 1'b0;  ram_re = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type;  op_nxt = in_opcode;
          tag_nxt = in_cmd_tag;  st_nxt = in_answer_status;
          idx_nxt = '0;  n_nxt = '0;
          unique case (in_req_type) inside
            hcct_pkg::REQ_SEND: state_nxt = S_SEND;
            hcct_pkg::REQ_CREDITS: begin
              credits_nxt = in_credit_count;
              state_nxt = S_DCHK;
            end
            hcct_pkg::REQ_STATUS, hcct_pkg::REQ_COMPLETE: state_nxt = S_PRUNE;
            hcct_pkg::REQ_TICK: begin
              now_nxt = now_r + 32'd1;
              state_nxt = S_TICK;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SEND: begin
        if (out_free) begin
          emit = 1'b1;
          state_nxt = S_IDLE;
          if (credits_r != 8'd0) begin
            if (pend_full) begin
              e_oc = hcct_pkg::OC_PEND_FULL;
            end else begin
              pend_add = 1'b1;
              plen_nxt = plen_r + 1'b1;
              credits_nxt = credits_r - 8'd1;
            end
          end else if (count_r == hcct_pkg::CCW'(hcct_pkg::CACHE_DEPTH)) begin
            e_oc = hcct_pkg::OC_CACHE_FULL;
          end else begin
            ram_we = 1'b1;
            count_nxt = count_r + 1'b1;
            e_oc = hcct_pkg::OC_CACHED;
          end
        end
      end
      S_DCHK: begin
        if (credits_r != 8'd0 && count_r != '0 &&
            n_r < hcct_pkg::NW'(hcct_pkg::MAX_RESULTS)) begin
          ram_re = 1'b1;
          state_nxt = S_DEMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DEMIT: begin
        if (out_free) begin
          emit = 1'b1;
          e_op = ram_rdata.op;
          e_tag = ram_rdata.tag;
          pend_new.tag = ram_rdata.tag;
          pend_new.op = ram_rdata.op;
          head_nxt = (head_r == hcct_pkg::CAW'(hcct_pkg::CACHE_DEPTH - 1))
                     ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          n_nxt = n_r + 1'b1;
          if (pend_full) begin
            e_oc = hcct_pkg::OC_PEND_FULL;
          end else begin
            pend_add = 1'b1;
            plen_nxt = plen_r + 1'b1;
            credits_nxt = credits_r - 8'd1;
          end
          e_last = !(cred_after != 8'd0 && count_r != hcct_pkg::CCW'(1) &&
                     n_nxt < hcct_pkg::NW'(hcct_pkg::MAX_RESULTS));
          state_nxt = e_last ? S_IDLE : S_DCHK;
        end
      end
      S_PRUNE: begin
        if (idx_r < hcct_pkg::SW'(elen_r)) begin
          if (ediff > {16'd0, absorb_r}) begin
            exp_rm = 1'b1;
            elen_nxt = elen_r - 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          idx_nxt = '0;
          state_nxt = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (idx_r < hcct_pkg::SW'(plen_r)) begin
          if (pcur.op == op_r) begin
            state_nxt = S_AEMIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          idx_nxt = '0;
          state_nxt = S_ESCAN;
        end
      end
      S_ESCAN: begin
        if (idx_r < hcct_pkg::SW'(elen_r)) begin
          if (ecur.op == op_r) begin
            if (out_free) begin
              emit = 1'b1;
              e_oc = hcct_pkg::OC_ABSORBED;
              e_tag = 8'd0;
              exp_rm = 1'b1;
              elen_nxt = elen_r - 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (out_free) begin
          emit = 1'b1;
          e_oc = hcct_pkg::OC_NO_PENDING;
          e_tag = 8'd0;
          state_nxt = S_IDLE;
        end
      end
      S_AEMIT: begin
        if (out_free) begin
          emit = 1'b1;
          e_tag = pcur.tag;
          pend_rm = 1'b1;
          plen_nxt = plen_r - 1'b1;
          if (req_r == hcct_pkg::REQ_COMPLETE || st_r == 8'd0) begin
            e_oc = (req_r == hcct_pkg::REQ_STATUS && op_r == disc_r)
                   ? hcct_pkg::OC_DISCONNECT : hcct_pkg::OC_OK;
          end else begin
            e_oc = hcct_pkg::OC_FAILED;
            e_st = st_r;
          end
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (idx_r < hcct_pkg::SW'(plen_r) &&
            n_r < hcct_pkg::NW'(hcct_pkg::MAX_RESULTS)) begin
          if (!pdiff[31]) begin
            if (!hold_v_r || out_free) begin
              emit = hold_v_r;
              e_oc = hold_oc_r;  e_op = hold_op_r;  e_tag = hold_tag_r;
              e_last = 1'b0;
              hold_v_nxt = 1'b1;
              hold_op_nxt = pcur.op;
              hold_tag_nxt = pcur.tag;
              hold_oc_nxt = (pcur.op != 16'd0) ? hcct_pkg::OC_TIMEOUT
                                               : hcct_pkg::OC_TIMEOUT_ZERO;
              pend_rm = 1'b1;
              plen_nxt = plen_r - 1'b1;
              if (pcur.op != 16'd0 &&
                  elen_r != hcct_pkg::ELW'(hcct_pkg::EXPIRED_DEPTH)) begin
                exp_add = 1'b1;
                elen_nxt = elen_r + 1'b1;
              end
              n_nxt = n_r + 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          state_nxt = S_TFLUSH;
        end
      end
      S_TFLUSH: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          emit = 1'b1;
          e_oc = hold_oc_r;  e_op = hold_op_r;  e_tag = hold_tag_r;
          hold_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ov_nxt = ov_r;  oc_nxt = oc_r;  oop_nxt = oop_r;
    otag_nxt = otag_r;  ost_nxt = ost_r;  ol_nxt = ol_r;
    if (emit) begin
      ov_nxt = 1'b1;  oc_nxt = e_oc;  oop_nxt = e_op;
      otag_nxt = e_tag;  ost_nxt = e_st;  ol_nxt = e_last;
    end else if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= hcct_pkg::TIMEOUT_RESET;
      absorb_r  <= hcct_pkg::ABSORB_RESET;
      disc_r    <= hcct_pkg::DISCONNECT_RESET;
      state_r   <= S_IDLE;
      credits_r <= 8'd1;
      now_r     <= '0;
      count_r   <= '0;
      head_r    <= '0;
      plen_r    <= '0;
      elen_r    <= '0;
      hold_v_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hcct_pkg::CFG_TIMEOUT:    timeout_r <= cfg_wdata;
          hcct_pkg::CFG_ABSORB:     absorb_r  <= cfg_wdata;
          hcct_pkg::CFG_DISCONNECT: disc_r    <= cfg_wdata;
          default: ;
        endcase
      end
      state_r   <= state_nxt;
      credits_r <= credits_nxt;
      now_r     <= now_nxt;
      count_r   <= count_nxt;
      head_r    <= head_nxt;
      plen_r    <= plen_nxt;
      elen_r    <= elen_nxt;
      hold_v_r  <= hold_v_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;  op_r <= op_nxt;  tag_r <= tag_nxt;  st_r <= st_nxt;
    idx_r <= idx_nxt;  n_r <= n_nxt;
    hold_oc_r <= hold_oc_nxt;  hold_op_r <= hold_op_nxt;
    hold_tag_r <= hold_tag_nxt;
    oc_r <= oc_nxt;  oop_r <= oop_nxt;  otag_r <= otag_nxt;
    ost_r <= ost_nxt;  ol_r <= ol_nxt;
    for (int k = 0; k < hcct_pkg::PENDING_DEPTH; k++) begin
      if (pend_rm && hcct_pkg::SW'(k) >= rm_idx &&
          hcct_pkg::PLW'(k + 1) < plen_r) begin
        pend_r[k] <= pend_r[(k + 1) % hcct_pkg::PENDING_DEPTH];
      end
      if (pend_add && hcct_pkg::PLW'(k) == plen_r) begin
        pend_r[k] <= pend_new;
      end
    end
    for (int k = 0; k < hcct_pkg::EXPIRED_DEPTH; k++) begin
      if (exp_rm && hcct_pkg::SW'(k) >= rm_idx &&
          hcct_pkg::ELW'(k + 1) < elen_r) begin
        exp_r[k] <= exp_r[(k + 1) % hcct_pkg::EXPIRED_DEPTH];
      end
      if (exp_add && hcct_pkg::ELW'(k) == elen_r) begin
        exp_r[k] <= '{stamp: now_r, op: pcur.op};
      end
    end
  end

  assign out_valid   = ov_r;
  assign out_outcome = oc_r;
  assign out_opcode  = oop_r;
  assign out_tag     = otag_r;
  assign out_status  = ost_r;
  assign out_last    = ol_r;

endmodule

// ----- rtl/hcct_cache_ram.sv -----
// ----------------------------------------------------------------------------
// Command cache memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hcct_cache_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [hcct_pkg::CAW-1:0] waddr,
  input  hcct_pkg::cache_entry_t   wdata,
  input  logic                     re,
  input  logic [hcct_pkg::CAW-1:0] raddr,
  output hcct_pkg::cache_entry_t   rdata
);

  hcct_pkg::cache_entry_t mem [hcct_pkg::CACHE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/hcct_checker.sv -----
// ----------------------------------------------------------------------------
// HCI command credit tracker checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hcct_port_assert (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_outcome,
  input logic [15:0] out_opcode,
  input logic [7:0]  out_tag,
  input logic [7:0]  out_status,
  input logic        out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_outcome) &&
    $stable(out_opcode) && $stable(out_tag) && $stable(out_status) &&
    $stable(out_last))
    else $error("Stalled result transaction changed.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_outcome <= hcct_pkg::OC_DISCONNECT)
    else $error("Outcome code out of range.");

  a_notag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == hcct_pkg::OC_ABSORBED ||
                  out_outcome == hcct_pkg::OC_NO_PENDING) |-> out_tag == 8'd0)
    else $error("Unmatched answer carries a tag.");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != hcct_pkg::OC_FAILED |-> out_status == 8'd0)
    else $error("Status set on a result that is not a failure.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind hci_command_credit_tracker hcct_port_assert u_hcct_port_assert (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_outcome (out_outcome),
  .out_opcode  (out_opcode),
  .out_tag     (out_tag),
  .out_status  (out_status),
  .out_last    (out_last)
);

// ----- bench/hcct_checker.sv -----
// ----------------------------------------------------------------------------
// HCI command credit tracker checker
// Watches the configuration port and both channels, predicts every result of
// each accepted transaction and compares the results in order.
// ----------------------------------------------------------------------------
module hcct_checker
  import hcct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_opcode,
  input  logic [7:0]  in_cmd_tag,
  input  logic [7:0]  in_answer_status,
  input  logic [7:0]  in_credit_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_outcome,
  input  logic [15:0] out_opcode,
  input  logic [7:0]  out_tag,
  input  logic [7:0]  out_status,
  input  logic        out_last,
  output int          fails,
  output int          waiting
);

  typedef struct packed {
    logic [3:0]  outcome;
    logic [15:0] op;
    logic [7:0]  tag;
    logic [7:0]  status;
    logic        last;
  } result_t;

  result_t      expected_q[$];
  logic [15:0]  timeout_ms;
  logic [15:0]  absorb_ms;
  logic [15:0]  disc_op;
  logic [7:0]   credits;
  logic [31:0]  now_ms;
  cache_entry_t cache_mem[CACHE_DEPTH];
  int           cache_cnt;
  int           cache_rd;
  pend_entry_t  pend_tab[PENDING_DEPTH];
  int           pend_cnt;
  exp_entry_t   exp_tab[EXPIRED_DEPTH];
  int           exp_cnt;
  int           step_n;

  function automatic void post(logic [3:0] oc, logic [15:0] op, logic [7:0] tag,
                               logic [7:0] st);
    result_t r;
    r = '{oc, op, tag, st, 1'b0};
    expected_q.push_back(r);
    step_n++;
  endfunction

  function automatic void drop_pend(int i);
    for (int k = i; k + 1 < pend_cnt; k++) pend_tab[k] = pend_tab[k + 1];
    pend_cnt--;
  endfunction

  function automatic void drop_exp(int i);
    for (int k = i; k + 1 < exp_cnt; k++) exp_tab[k] = exp_tab[k + 1];
    exp_cnt--;
  endfunction

  function automatic void launch(logic [15:0] op, logic [7:0] tag);
    if (pend_cnt >= PENDING_DEPTH) begin
      post(OC_PEND_FULL, op, tag, 8'd0);
    end else begin
      pend_tab[pend_cnt] = '{now_ms + 32'(timeout_ms), tag, op};
      pend_cnt++;
      credits = credits - 8'd1;
      post(OC_TRANSMIT, op, tag, 8'd0);
    end
  endfunction

  function automatic bit try_absorb(logic [15:0] op);
    int i;
    logic [31:0] age;
    i = 0;
    while (i < exp_cnt) begin
      age = now_ms - exp_tab[i].stamp;
      if (age > 32'(absorb_ms)) drop_exp(i);
      else i++;
    end
    for (int k = 0; k < pend_cnt; k++) if (pend_tab[k].op == op) return 1'b0;
    for (int k = 0; k < exp_cnt; k++) begin
      if (exp_tab[k].op == op) begin
        drop_exp(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_step(logic [2:0] req, logic [15:0] op, logic [7:0] tag,
                                       logic [7:0] st, logic [7:0] cc);
    int i;
    logic [31:0] d;
    cache_entry_t c;
    pend_entry_t p;
    step_n = 0;
    case (req)
      REQ_SEND: begin
        if (credits != 0) begin
          launch(op, tag);
        end else if (cache_cnt >= CACHE_DEPTH) begin
          post(OC_CACHE_FULL, op, tag, 8'd0);
        end else begin
          cache_mem[(cache_rd + cache_cnt) % CACHE_DEPTH] = '{tag, op};
          cache_cnt++;
          post(OC_CACHED, op, tag, 8'd0);
        end
      end
      REQ_CREDITS: begin
        credits = cc;
        while (credits != 0 && cache_cnt > 0 && step_n < MAX_RESULTS) begin
          c = cache_mem[cache_rd];
          cache_rd = (cache_rd + 1) % CACHE_DEPTH;
          cache_cnt--;
          launch(c.op, c.tag);
        end
      end
      REQ_STATUS, REQ_COMPLETE: begin
        if (try_absorb(op)) begin
          post(OC_ABSORBED, op, 8'd0, 8'd0);
        end else begin
          for (i = 0; i < pend_cnt; i++) if (pend_tab[i].op == op) break;
          if (i >= pend_cnt) begin
            post(OC_NO_PENDING, op, 8'd0, 8'd0);
          end else begin
            p = pend_tab[i];
            drop_pend(i);
            if (req == REQ_COMPLETE || st == 0)
              post((req == REQ_STATUS && op == disc_op) ? OC_DISCONNECT : OC_OK,
                   op, p.tag, 8'd0);
            else
              post(OC_FAILED, op, p.tag, st);
          end
        end
      end
      REQ_TICK: begin
        now_ms = now_ms + 32'd1;
        i = 0;
        while (i < pend_cnt && step_n < MAX_RESULTS) begin
          d = now_ms - pend_tab[i].dl;
          if (!d[31]) begin
            p = pend_tab[i];
            drop_pend(i);
            if (p.op != 0) begin
              if (exp_cnt < EXPIRED_DEPTH) begin
                exp_tab[exp_cnt] = '{now_ms, p.op};
                exp_cnt++;
              end
              post(OC_TIMEOUT, p.op, p.tag, 8'd0);
            end else begin
              post(OC_TIMEOUT_ZERO, 16'd0, p.tag, 8'd0);
            end
          end else begin
            i++;
          end
        end
      end
      default: ;
    endcase
    if (step_n > 0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    result_t r;
    if (!rst_n) begin
      expected_q.delete();
      timeout_ms = TIMEOUT_RESET;
      absorb_ms  = ABSORB_RESET;
      disc_op    = DISCONNECT_RESET;
      credits    = 8'd1;
      now_ms     = 32'd0;
      cache_cnt  = 0;
      cache_rd   = 0;
      pend_cnt   = 0;
      exp_cnt    = 0;
      fails      = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT:    timeout_ms = cfg_wdata;
          CFG_ABSORB:     absorb_ms  = cfg_wdata;
          CFG_DISCONNECT: disc_op    = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got outcome %0d opcode %0h",
                   $time, out_outcome, out_opcode);
          fails++;
        end else begin
          r = expected_q.pop_front();
          check_field("outcome", r.outcome, out_outcome);
          check_field("opcode", r.op, out_opcode);
          check_field("tag", r.tag, out_tag);
          check_field("status", r.status, out_status);
          check_field("last", r.last, out_last);
        end
      end
      if (in_valid && !in_stall)
        predict_step(in_req_type, in_opcode, in_cmd_tag, in_answer_status, in_credit_count);
    end
    waiting = expected_q.size();
  end

endmodule

// ----- bench/tb_hci_command_credit_tracker.sv -----
// ----------------------------------------------------------------------------
// HCI command credit tracker testbench
// Directed and random send, credit, answer and tick transactions under several
// register settings, with random idling on both channels and a long result
// hold-off; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_hci_command_credit_tracker;
  import hcct_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_req_type;
  logic [15:0] in_opcode;
  logic [7:0]  in_cmd_tag;
  logic [7:0]  in_answer_status;
  logic [7:0]  in_credit_count;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_outcome;
  logic [15:0] out_opcode;
  logic [7:0]  out_tag;
  logic [7:0]  out_status;
  logic        out_last;
  int          fails;
  int          waiting;
  bit          idle_on;
  bit          hold_long;
  int          quiet_cycles;
  logic [15:0] disc_cur;

  hci_command_credit_tracker dut (.*);
  hcct_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] pick_op();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'd1030;
      2: return 16'hFFFF;
      3: return 16'h0C03;
      4: return 16'h2001;
      5: return disc_cur;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_item(logic [2:0] req, logic [15:0] op, logic [7:0] tag,
                           logic [7:0] st, logic [7:0] cc);
    int w;
    w = idle_on ? $urandom_range(0, 9) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_req_type      <= req;
    in_opcode        <= op;
    in_cmd_tag       <= tag;
    in_answer_status <= st;
    in_credit_count  <= cc;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic rand_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)
      push_item(REQ_SEND, pick_op(), 8'($urandom), 8'($urandom), 8'($urandom));
    else if (r < 47)
      push_item(REQ_CREDITS, 16'($urandom), 8'($urandom), 8'($urandom),
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)));
    else if (r < 75)
      push_item((r < 62) ? REQ_STATUS : REQ_COMPLETE, pick_op(), 8'($urandom),
                $urandom_range(0, 1) ? 8'd0 : 8'($urandom), 8'($urandom));
    else if (r < 95)
      push_item(REQ_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    else
      push_item(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic configure(logic [15:0] t, logic [15:0] a, logic [15:0] d);
    logic [15:0] vals[4];
    vals = '{t, a, d, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we   <= 1'b0;
    disc_cur = d;
    @(negedge clk);
  endtask

  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
      end else begin
        w = idle_on ? $urandom_range(0, 9) : 0;
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!(out_valid && !out_stall));
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_opcode = '0;
    in_cmd_tag = '0;
    in_answer_status = '0;
    in_credit_count = '0;
    idle_on = 1'b1;
    hold_long = 1'b0;
    quiet_cycles = 0;
    disc_cur = DISCONNECT_RESET;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    push_item(REQ_SEND, 16'd1030, 8'h01, 8'h00, 8'h00);
    push_item(REQ_SEND, 16'h0001, 8'h02, 8'h00, 8'h00);
    push_item(REQ_STATUS, 16'd1030, 8'h00, 8'h00, 8'h00);
    push_item(REQ_CREDITS, 16'h0000, 8'h00, 8'h00, 8'h03);
    push_item(REQ_COMPLETE, 16'h0001, 8'h00, 8'h00, 8'h00);
    push_item(REQ_STATUS, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_item(REQ_SEND, 16'hFFFF, 8'hFF, 8'h00, 8'h00);
    push_item(REQ_STATUS, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
    push_item(REQ_SEND, 16'd1030, 8'h07, 8'h00, 8'h00);
    push_item(REQ_STATUS, 16'd1030, 8'h00, 8'h05, 8'h00);
    for (int i = 5; i < 8; i++) push_item(3'(i), 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);

    settle();
    configure(16'd1, 16'd1, 16'd0);
    push_item(REQ_CREDITS, 16'h0000, 8'h00, 8'h00, 8'hFF);
    push_item(REQ_SEND, 16'h0000, 8'hAA, 8'h00, 8'h00);
    push_item(REQ_SEND, 16'h1234, 8'h55, 8'h00, 8'h00);
    push_item(REQ_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
    push_item(REQ_STATUS, 16'h1234, 8'h00, 8'h00, 8'h00);
    push_item(REQ_COMPLETE, 16'h1234, 8'h00, 8'h00, 8'h00);
    push_item(REQ_SEND, 16'h2001, 8'h33, 8'h00, 8'h00);
    push_item(REQ_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
    push_item(REQ_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
    push_item(REQ_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
    push_item(REQ_STATUS, 16'h2001, 8'h00, 8'h00, 8'h00);

    settle();
    configure(16'd65535, 16'd65535, 16'd1030);
    push_item(REQ_CREDITS, 16'h0000, 8'h00, 8'h00, 8'h00);
    hold_long = 1'b1;
    for (int i = 0; i < 34; i++)
      push_item(REQ_SEND, pick_op(), 8'($urandom), 8'h00, 8'h00);
    push_item(REQ_CREDITS, 16'h0000, 8'h00, 8'h00, 8'hFF);
    push_item(REQ_CREDITS, 16'h0000, 8'h00, 8'h00, 8'hFF);
    for (int i = 0; i < 10; i++) rand_item();

    settle();
    configure(16'd3, 16'd5, pick_op());
    for (int i = 0; i < 12; i++) rand_item();
    idle_on = 1'b0;
    for (int i = 0; i < 12; i++) rand_item();
    idle_on = 1'b1;

    settle();
    configure(16'd1, 16'd65535, 16'd0);
    push_item(REQ_CREDITS, 16'h0000, 8'h00, 8'h00, 8'hFF);
    for (int i = 0; i < 18; i++)
      push_item(REQ_SEND, 16'($urandom_range(1, 65535)), 8'($urandom), 8'h00, 8'h00);
    push_item(REQ_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 15; i++) rand_item();

    settle();
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
